### src/upp_pkg.sv
package upp_pkg;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BAD_BASE = 2'd2;

    localparam int BASE_BITS = 6;

    localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_BITS-1:0] LETTER_OFFSET = 6'd10;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

endpackage

### src/upp_if.sv
interface upp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       string_start;

    modport source (output valid, output char_code, output string_start, input ready);
    modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

interface upp_result_if #(
    parameter int VALUE_BITS    = 32,
    parameter int POSITION_BITS = 16
);
    logic                     valid;
    logic                     ready;
    logic [VALUE_BITS-1:0]    value;
    logic [POSITION_BITS-1:0] stop_index;
    logic [1:0]               status;

    modport source (output valid, output value, output stop_index, output status, input ready);
    modport sink   (input valid, input value, input stop_index, input status, output ready);
endinterface

### src/unsigned_number_text_parser.sv
// Converts an unsigned number written as text, one character per item, into a
// VALUE_BITS-wide value. Leading white space, one plus sign and more white
// space are skipped; number_base picks radix 2..36, or 0 for detection from
// the text ("0x" hexadecimal, leading "0" octal, otherwise decimal). The first
// character that is not a digit of the base (NUL included) gives one result
// item with the value, the offset of that character and a status; later
// characters give nothing until string_start marks a new string. The block
// takes one character every cycle unless a result waits for the sink: each
// character passes an input register, one multiply-add by the base with an
// exact overflow check, and lands in the result register. An input is refused
// only while a finished result waits for the sink.
module unsigned_number_text_parser #(
    parameter int VALUE_BITS    = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [upp_pkg::BASE_BITS-1:0]      cfg_wr_data,
    upp_char_if.sink                           chars,
    upp_result_if.source                       results
);

    logic                              in_valid_reg;
    logic [7:0]                        in_char_reg;
    logic                              in_start_reg;
    logic [upp_pkg::BASE_BITS-1:0]     number_base_reg;
    upp_pkg::phase_t                   phase_reg;
    logic [VALUE_BITS-1:0]             acc_reg;
    logic [upp_pkg::BASE_BITS-1:0]     base_reg;
    logic [POSITION_BITS-1:0]          pos_reg;
    logic                              out_valid_reg;
    logic [VALUE_BITS-1:0]             out_value_reg;
    logic [POSITION_BITS-1:0]          out_pos_reg;
    logic [1:0]                        out_status_reg;

    upp_pkg::phase_t                   phase_next;
    logic [VALUE_BITS-1:0]             acc_next;
    logic [upp_pkg::BASE_BITS-1:0]     base_next;
    logic [POSITION_BITS-1:0]          pos_next;
    logic                              res_valid;
    logic [VALUE_BITS-1:0]             res_value;
    logic [POSITION_BITS-1:0]          res_pos;
    logic [1:0]                        res_status;
    logic                              advance;
    logic                              in_take;

    // The held character is processed when the result register has room.
    assign advance       = in_valid_reg && (!out_valid_reg || results.ready);
    assign chars.ready   = !in_valid_reg || advance;
    assign in_take       = chars.valid && chars.ready;

    assign results.valid      = out_valid_reg;
    assign results.value      = out_value_reg;
    assign results.stop_index = out_pos_reg;
    assign results.status     = out_status_reg;

    upp_step #(
        .VALUE_BITS    (VALUE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .char_code    (in_char_reg),
        .string_start (in_start_reg),
        .number_base  (number_base_reg),
        .phase        (phase_reg),
        .acc          (acc_reg),
        .base         (base_reg),
        .pos          (pos_reg),
        .phase_next   (phase_next),
        .acc_next     (acc_next),
        .base_next    (base_next),
        .pos_next     (pos_next),
        .res_valid    (res_valid),
        .res_value    (res_value),
        .res_pos      (res_pos),
        .res_status   (res_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= upp_pkg::BASE_AUTO;
        end
        else if (cfg_wr_en)
        begin
            number_base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg  <= chars.char_code;
            in_start_reg <= chars.string_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= upp_pkg::PH_LEAD;
            acc_reg   <= '0;
            base_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_value_reg  <= res_value;
            out_pos_reg    <= res_pos;
            out_status_reg <= res_status;
        end
    end

endmodule

### src/upp_step.sv
module upp_step #(
    parameter int VALUE_BITS    = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic [7:0]                        char_code,
    input  logic                              string_start,
    input  logic [upp_pkg::BASE_BITS-1:0]     number_base,
    input  upp_pkg::phase_t                   phase,
    input  logic [VALUE_BITS-1:0]             acc,
    input  logic [upp_pkg::BASE_BITS-1:0]     base,
    input  logic [POSITION_BITS-1:0]          pos,
    output upp_pkg::phase_t                   phase_next,
    output logic [VALUE_BITS-1:0]             acc_next,
    output logic [upp_pkg::BASE_BITS-1:0]     base_next,
    output logic [POSITION_BITS-1:0]          pos_next,
    output logic                              res_valid,
    output logic [VALUE_BITS-1:0]             res_value,
    output logic [POSITION_BITS-1:0]          res_pos,
    output logic [1:0]                        res_status
);

    localparam int SUM_BITS = VALUE_BITS + upp_pkg::BASE_BITS + 1;

    upp_pkg::phase_t                  phase_e;
    logic [VALUE_BITS-1:0]            acc_e;
    logic [upp_pkg::BASE_BITS-1:0]    base_e;
    logic [POSITION_BITS-1:0]         pos_e;
    logic [POSITION_BITS-1:0]         pos_inc;
    logic                             is_space;
    logic                             is_plus;
    logic                             is_x;
    logic                             auto_mode;
    logic                             cfg_ok;
    logic                             lead_zero;
    logic                             dig_valid;
    logic [upp_pkg::BASE_BITS-1:0]    digit;
    logic [upp_pkg::BASE_BITS-1:0]    take_base;
    logic [SUM_BITS-1:0]              sum;
    logic                             digit_ok;
    logic                             overflow;
    logic                             skip_char;

    // A new string restarts the scan before this character is looked at.
    assign phase_e = string_start ? upp_pkg::PH_LEAD : phase;
    assign acc_e   = string_start ? '0 : acc;
    assign base_e  = string_start ? '0 : base;
    assign pos_e   = string_start ? '0 : pos;
    assign pos_inc = (pos_e == '1) ? pos_e : pos_e + 1'b1;

    assign is_space  = (char_code == upp_pkg::CH_SPACE) ||
                       (char_code >= upp_pkg::CH_TAB && char_code <= upp_pkg::CH_CR);
    assign is_plus   = (char_code == upp_pkg::CH_PLUS);
    assign is_x      = (char_code == upp_pkg::CH_UPPER_X) || (char_code == upp_pkg::CH_LOWER_X);
    assign auto_mode = (number_base == upp_pkg::BASE_AUTO);
    assign cfg_ok    = (number_base >= upp_pkg::BASE_MIN) && (number_base <= upp_pkg::BASE_MAX);
    assign lead_zero = auto_mode && (char_code == upp_pkg::CH_ZERO);

    always_comb
    begin
        dig_valid = 1'b1;
        digit     = '0;
        if (char_code inside {[upp_pkg::CH_ZERO : upp_pkg::CH_NINE]})
        begin
            digit = upp_pkg::BASE_BITS'(char_code - upp_pkg::CH_ZERO);
        end
        else if (char_code inside {[upp_pkg::CH_UPPER_A : upp_pkg::CH_UPPER_Z]})
        begin
            digit = upp_pkg::BASE_BITS'(char_code - upp_pkg::CH_UPPER_A) + upp_pkg::LETTER_OFFSET;
        end
        else if (char_code inside {[upp_pkg::CH_LOWER_A : upp_pkg::CH_LOWER_Z]})
        begin
            digit = upp_pkg::BASE_BITS'(char_code - upp_pkg::CH_LOWER_A) + upp_pkg::LETTER_OFFSET;
        end
        else
        begin
            dig_valid = 1'b0;
        end
    end

    // Base used if this character is taken as a digit.
    always_comb
    begin
        case (phase_e)
            upp_pkg::PH_ZERO:   take_base = upp_pkg::BASE_OCT;
            upp_pkg::PH_DIGITS: take_base = base_e;
            default:            take_base = auto_mode ? upp_pkg::BASE_DEC : number_base;
        endcase
    end

    // Exact overflow check: the new value overflows when the full-width sum does.
    assign sum      = SUM_BITS'(acc_e) * SUM_BITS'(take_base) + SUM_BITS'(digit);
    assign digit_ok = dig_valid && (take_base >= upp_pkg::BASE_MIN) && (digit < take_base);
    assign overflow = |sum[SUM_BITS-1:VALUE_BITS];

    // Characters that are consumed in the white space, sign or prefix phases.
    always_comb
    begin
        case (phase_e)
            upp_pkg::PH_LEAD:   skip_char = is_space || is_plus || lead_zero;
            upp_pkg::PH_SIGNED: skip_char = is_space || lead_zero;
            upp_pkg::PH_ZERO:   skip_char = is_x;
            default:            skip_char = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_e;
        case (phase_e)
            upp_pkg::PH_LEAD,
            upp_pkg::PH_SIGNED:
            begin
                if (is_space)
                    phase_next = phase_e;
                else if (is_plus && phase_e == upp_pkg::PH_LEAD)
                    phase_next = upp_pkg::PH_SIGNED;
                else if (lead_zero)
                    phase_next = upp_pkg::PH_ZERO;
                else if (!auto_mode && !cfg_ok)
                    phase_next = upp_pkg::PH_DONE;
                else if (digit_ok && !overflow)
                    phase_next = upp_pkg::PH_DIGITS;
                else
                    phase_next = upp_pkg::PH_DONE;
            end
            upp_pkg::PH_ZERO,
            upp_pkg::PH_DIGITS:
            begin
                if (is_x && phase_e == upp_pkg::PH_ZERO)
                    phase_next = upp_pkg::PH_DIGITS;
                else if (digit_ok && !overflow)
                    phase_next = upp_pkg::PH_DIGITS;
                else
                    phase_next = upp_pkg::PH_DONE;
            end
            default: phase_next = upp_pkg::PH_DONE;
        endcase
    end

    always_comb
    begin
        acc_next   = acc_e;
        base_next  = base_e;
        pos_next   = pos_e;
        res_valid  = 1'b0;
        res_value  = acc_e;
        res_pos    = pos_e;
        res_status = upp_pkg::ST_OK;
        if (phase_e != upp_pkg::PH_DONE)
        begin
            if (skip_char)
            begin
                pos_next = pos_inc;
                if (phase_e == upp_pkg::PH_ZERO)
                    base_next = upp_pkg::BASE_HEX;
            end
            else if ((phase_e == upp_pkg::PH_LEAD || phase_e == upp_pkg::PH_SIGNED) &&
                     !auto_mode && !cfg_ok)
            begin
                base_next  = '0;
                res_valid  = 1'b1;
                res_value  = '0;
                res_status = upp_pkg::ST_BAD_BASE;
            end
            else
            begin
                base_next = take_base;
                if (!digit_ok)
                begin
                    res_valid = 1'b1;
                end
                else if (overflow)
                begin
                    res_valid  = 1'b1;
                    res_value  = '1;
                    res_status = upp_pkg::ST_OVERFLOW;
                end
                else
                begin
                    acc_next = sum[VALUE_BITS-1:0];
                    pos_next = pos_inc;
                end
            end
        end
    end

endmodule

### src/upp_checker.sv
module upp_checker #(
    parameter int VALUE_BITS    = 32,
    parameter int POSITION_BITS = 16
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [VALUE_BITS-1:0]    out_value,
    input logic [POSITION_BITS-1:0] out_stop_index,
    input logic [1:0]               out_status
);

    // A waiting result item must not vanish.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_stop_index))
        else $error("result item dropped while stalled");

    // A result rising from an empty output register comes from a character taken
    // into the input register and then processed into the result register.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result item without a character behind it");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status == upp_pkg::ST_OK || out_status == upp_pkg::ST_OVERFLOW ||
                      out_status == upp_pkg::ST_BAD_BASE)
        else $error("undefined status code");

    a_overflow_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == upp_pkg::ST_OVERFLOW |-> out_value == '1)
        else $error("overflow result is not saturated");

    a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == upp_pkg::ST_BAD_BASE |-> out_value == '0)
        else $error("invalid base result carries a value");

endmodule

bind unsigned_number_text_parser upp_checker #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (chars.valid),
    .in_ready       (chars.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_value      (results.value),
    .out_stop_index (results.stop_index),
    .out_status     (results.status)
);

### tb/unsigned_number_text_parser_test.sv
`timescale 1ns / 1ps

module unsigned_number_text_parser_test;

    localparam int VALUE_BITS    = 32;
    localparam int POSITION_BITS = 16;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic [VALUE_BITS-1:0]    value;
        logic [POSITION_BITS-1:0] stop_index;
        logic [1:0]               status;
    } parsed_number_t;

    typedef struct {
        logic [7:0]     code;
        logic           first;
        int             new_base;
        bit             typed;
        parsed_number_t want;
    } text_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [upp_pkg::BASE_BITS-1:0] cfg_wr_data;

    upp_char_if chars();
    upp_result_if #(.VALUE_BITS(VALUE_BITS), .POSITION_BITS(POSITION_BITS)) results();

    unsigned_number_text_parser #(
        .VALUE_BITS    (VALUE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .chars       (chars),
        .results     (results)
    );

    // Scanner state mirrored from the block's behavior.
    upp_pkg::phase_t               scan_ph;
    logic [VALUE_BITS-1:0]         scan_acc;
    logic [upp_pkg::BASE_BITS-1:0] scan_base;
    logic [POSITION_BITS-1:0]      scan_pos;
    logic [upp_pkg::BASE_BITS-1:0] cfg_base;

    parsed_number_t parsed_numbers[$];
    text_row_t      script[$];

    int  mismatches;
    int  numbers_checked;
    int  live_items;
    int  bases_used;
    int  cycle_count;
    int  src_idle_pct;
    int  snk_stall_pct;
    logic holding;
    event hold_trigger;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run timed out after %0d cycles.", cycle_count);
            $display("** unsigned_number_text_parser: FAILED **");
            $finish;
        end
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == upp_pkg::CH_SPACE || (c >= upp_pkg::CH_TAB && c <= upp_pkg::CH_CR);
    endfunction

    function automatic void bump_pos();
        if (scan_pos != '1)
            scan_pos = scan_pos + 1'b1;
    endfunction

    function automatic bit close_scan(input logic [VALUE_BITS-1:0] v, input logic [1:0] st,
                                      output parsed_number_t r);
        r.value      = v;
        r.stop_index = scan_pos;
        r.status     = st;
        scan_ph      = upp_pkg::PH_DONE;
        return 1'b1;
    endfunction

    function automatic bit take_digit(input logic [7:0] c, output parsed_number_t r);
        logic [7:0]  d;
        logic [63:0] grown;
        r = '0;
        if (c >= upp_pkg::CH_ZERO && c <= upp_pkg::CH_NINE)
            d = c - upp_pkg::CH_ZERO;
        else if (c >= upp_pkg::CH_UPPER_A && c <= upp_pkg::CH_UPPER_Z)
            d = c - upp_pkg::CH_UPPER_A + 8'(upp_pkg::LETTER_OFFSET);
        else if (c >= upp_pkg::CH_LOWER_A && c <= upp_pkg::CH_LOWER_Z)
            d = c - upp_pkg::CH_LOWER_A + 8'(upp_pkg::LETTER_OFFSET);
        else
            return close_scan(scan_acc, upp_pkg::ST_OK, r);
        if (scan_base < upp_pkg::BASE_MIN || d >= 8'(scan_base))
            return close_scan(scan_acc, upp_pkg::ST_OK, r);
        grown = 64'(scan_acc) * 64'(scan_base) + 64'(d);
        if (grown > 64'(VALUE_MAX))
            return close_scan(VALUE_MAX, upp_pkg::ST_OVERFLOW, r);
        scan_acc = grown[VALUE_BITS-1:0];
        bump_pos();
        return 1'b0;
    endfunction

    function automatic bit start_number(input logic [7:0] c, output parsed_number_t r);
        r = '0;
        if (cfg_base == upp_pkg::BASE_AUTO)
        begin
            if (c == upp_pkg::CH_ZERO)
            begin
                bump_pos();
                scan_ph = upp_pkg::PH_ZERO;
                return 1'b0;
            end
            scan_base = upp_pkg::BASE_DEC;
        end
        else if (cfg_base >= upp_pkg::BASE_MIN && cfg_base <= upp_pkg::BASE_MAX)
            scan_base = cfg_base;
        else
        begin
            scan_base = '0;
            return close_scan('0, upp_pkg::ST_BAD_BASE, r);
        end
        scan_ph = upp_pkg::PH_DIGITS;
        return take_digit(c, r);
    endfunction

    // Returns 1 when the character closes the number and fills r.
    function automatic bit scan_char(input logic [7:0] c, input logic s, output parsed_number_t r);
        r = '0;
        if (s)
        begin
            scan_ph   = upp_pkg::PH_LEAD;
            scan_acc  = '0;
            scan_base = '0;
            scan_pos  = '0;
        end
        case (scan_ph)
            upp_pkg::PH_LEAD:
            begin
                if (is_blank(c))
                begin
                    bump_pos();
                    return 1'b0;
                end
                if (c == upp_pkg::CH_PLUS)
                begin
                    bump_pos();
                    scan_ph = upp_pkg::PH_SIGNED;
                    return 1'b0;
                end
                return start_number(c, r);
            end
            upp_pkg::PH_SIGNED:
            begin
                if (is_blank(c))
                begin
                    bump_pos();
                    return 1'b0;
                end
                return start_number(c, r);
            end
            upp_pkg::PH_ZERO:
            begin
                if (c == upp_pkg::CH_UPPER_X || c == upp_pkg::CH_LOWER_X)
                begin
                    scan_base = upp_pkg::BASE_HEX;
                    bump_pos();
                    scan_ph = upp_pkg::PH_DIGITS;
                    return 1'b0;
                end
                scan_base = upp_pkg::BASE_OCT;
                scan_ph = upp_pkg::PH_DIGITS;
                return take_digit(c, r);
            end
            upp_pkg::PH_DIGITS:
                return take_digit(c, r);
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? upp_pkg::CH_SPACE : upp_pkg::CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return upp_pkg::CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? upp_pkg::CH_UPPER_A : upp_pkg::CH_LOWER_A) + 8'(d - 10);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("Mismatch in %s at cycle %0d: expected %0h, got %0h",
                 what, cycle_count, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        parsed_number_t exp;
        if (rst_n && results.valid && results.ready)
        begin
            if (parsed_numbers.size() == 0)
                report_mismatch("unexpected result value", '0, 64'(results.value));
            else
            begin
                exp = parsed_numbers.pop_front();
                if (results.value !== exp.value)
                    report_mismatch("value", 64'(exp.value), 64'(results.value));
                if (results.stop_index !== exp.stop_index)
                    report_mismatch("stop_index", 64'(exp.stop_index),
                                    64'(results.stop_index));
                if (results.status !== exp.status)
                    report_mismatch("status", 64'(exp.status), 64'(results.status));
                numbers_checked++;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
            results.ready <= !holding && ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Long receiver hold-off, so that a finished result blocks the input side.
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_trigger);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    task automatic offer_char(input logic [7:0] c, input logic s, input bit typed,
                              input parsed_number_t want);
        parsed_number_t got;
        bit made;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid        <= 1'b1;
        chars.char_code    <= c;
        chars.string_start <= s;
        do
            @(posedge clk);
        while (!chars.ready);
        made = scan_char(c, s, got);
        if (typed)
            parsed_numbers.push_back(want);
        else if (made)
            parsed_numbers.push_back(got);
    endtask

    task automatic settle();
        chars.valid <= 1'b0;
        while (parsed_numbers.size() != 0)
            @(posedge clk);
        // A character that closes nothing may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_number_base(input logic [upp_pkg::BASE_BITS-1:0] b);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_base = b;
        bases_used++;
    endtask

    task automatic add_row(input logic [7:0] code, input logic first, input int new_base = -1,
                           input bit typed = 0, input logic [VALUE_BITS-1:0] v = '0,
                           input logic [POSITION_BITS-1:0] idx = '0,
                           input logic [1:0] st = upp_pkg::ST_OK);
        text_row_t row;
        row.code     = code;
        row.first    = first;
        row.new_base = new_base;
        row.typed    = typed;
        row.want     = '{value: v, stop_index: idx, status: st};
        script.push_back(row);
    endtask

    // Mostly well-formed numbers with random content; some noise and broken text.
    task automatic send_string();
        logic [7:0] text[$];
        logic [upp_pkg::BASE_BITS-1:0] eff;
        int r;
        int n_dig;
        int n_tail;
        bit first_flag;
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 6))
            begin
                offer_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, '0);
                live_items++;
            end
            return;
        end
        repeat ($urandom_range(0, 3)) text.push_back(blank_char());
        if ($urandom_range(0, 99) < 30)
        begin
            text.push_back(upp_pkg::CH_PLUS);
            repeat ($urandom_range(0, 2)) text.push_back(blank_char());
            if ($urandom_range(0, 99) < 5)
                text.push_back(upp_pkg::CH_PLUS);
        end
        eff = (cfg_base >= upp_pkg::BASE_MIN && cfg_base <= upp_pkg::BASE_MAX) ?
              cfg_base : upp_pkg::BASE_DEC;
        if (cfg_base == upp_pkg::BASE_AUTO)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                text.push_back(upp_pkg::CH_ZERO);
                text.push_back($urandom_range(0, 1) ? upp_pkg::CH_UPPER_X : upp_pkg::CH_LOWER_X);
                eff = upp_pkg::BASE_HEX;
            end
            else if (r < 60)
            begin
                text.push_back(upp_pkg::CH_ZERO);
                eff = upp_pkg::BASE_OCT;
            end
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            n_dig = 0;
        else if (r < 75)
            n_dig = $urandom_range(1, 8);
        else
            n_dig = $urandom_range(9, 36);
        repeat (n_dig) text.push_back(digit_char($urandom_range(0, int'(eff) - 1)));
        r = $urandom_range(0, 99);
        if (r < 45)
            text.push_back(8'h00);
        else if (r < 75)
            text.push_back(8'($urandom_range(8'h21, 8'h2F)));
        else
            text.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 8)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        first_flag = $urandom_range(0, 99) < 92;
        foreach (text[i])
            offer_char(text[i], first_flag && i == 0, 0, '0);
        live_items += text.size();
        // Trailing characters after the number are ignored by the block once the number is closed.
        n_tail = $urandom_range(0, 2);
        repeat (n_tail) offer_char(8'($urandom_range(0, 255)), 1'b0, 0, '0);
        live_items += n_tail;
    endtask

    initial
    begin
        text_row_t row;
        logic [upp_pkg::BASE_BITS-1:0] b;
        int target;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        chars.valid        = 1'b0;
        chars.char_code    = '0;
        chars.string_start = 1'b0;
        results.ready      = 1'b0;
        src_idle_pct       = 0;
        snk_stall_pct      = 0;
        mismatches         = 0;
        numbers_checked    = 0;
        live_items         = 0;
        bases_used         = 0;
        cycle_count        = 0;
        scan_ph            = upp_pkg::PH_LEAD;
        scan_acc           = '0;
        scan_base          = '0;
        scan_pos           = '0;
        cfg_base           = upp_pkg::BASE_AUTO;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // First string right after reset, with no string_start: white space, sign, hex prefix.
        add_row(upp_pkg::CH_SPACE, 1'b0);
        add_row(upp_pkg::CH_PLUS, 1'b0);
        add_row(upp_pkg::CH_TAB, 1'b0);
        add_row(upp_pkg::CH_ZERO, 1'b0);
        add_row(upp_pkg::CH_UPPER_X, 1'b0);
        add_row(upp_pkg::CH_LOWER_A, 1'b0);
        add_row(8'h00, 1'b0);
        // Octal digits stop at a decimal digit that is not below eight.
        add_row(upp_pkg::CH_ZERO, 1'b1);
        add_row(8'h37, 1'b0);
        add_row(upp_pkg::CH_NINE, 1'b0);
        // Hex prefix with no hex digit after it.
        add_row(upp_pkg::CH_ZERO, 1'b1);
        add_row(upp_pkg::CH_LOWER_X, 1'b0);
        add_row(8'h67, 1'b0);
        // A lone zero.
        add_row(upp_pkg::CH_ZERO, 1'b1);
        add_row(8'h00, 1'b0, -1, 1, '0, 16'd1, upp_pkg::ST_OK);
        // A byte above ASCII stops at once; the next character is ignored.
        add_row(8'hFF, 1'b1, -1, 1, '0, 16'd0, upp_pkg::ST_OK);
        add_row(upp_pkg::CH_LOWER_A, 1'b0);
        // Invalid base.
        add_row(8'h35, 1'b1, 1, 1, '0, 16'd0, upp_pkg::ST_BAD_BASE);
        // Base 36 overflow on the seventh character.
        add_row(8'h31, 1'b1, int'(upp_pkg::BASE_MAX));
        repeat (5) add_row(upp_pkg::CH_UPPER_Z, 1'b0);
        add_row(upp_pkg::CH_UPPER_Z, 1'b0, -1, 1, VALUE_MAX, 16'd6, upp_pkg::ST_OVERFLOW);

        foreach (script[i])
        begin
            row = script[i];
            if (row.new_base >= 0)
                set_number_base(upp_pkg::BASE_BITS'(row.new_base));
            offer_char(row.code, row.first, row.typed, row.want);
            live_items++;
        end

        for (int seg = 0; seg < 12; seg++)
        begin
            case (seg)
                0:       b = upp_pkg::BASE_AUTO;
                1:       b = upp_pkg::BASE_DEC;
                2:       b = upp_pkg::BASE_HEX;
                3:       b = upp_pkg::BASE_MIN;
                4:       b = upp_pkg::BASE_MAX;
                5:       b = 6'd1;
                6:       b = upp_pkg::BASE_OCT;
                7:       b = 6'd63;
                8:       b = upp_pkg::BASE_AUTO;
                9:       b = 6'd37;
                default: b = upp_pkg::BASE_BITS'($urandom_range(0, 40));
            endcase
            set_number_base(b);
            case (seg % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 83;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 83;
                end
                default:
                begin
                    src_idle_pct  = 33;
                    snk_stall_pct = 33;
                end
            endcase
            target = live_items + 80;
            while (live_items < target)
                send_string();
        end

        // Receiver holds off while the sender keeps offering items.
        set_number_base(upp_pkg::BASE_AUTO);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        -> hold_trigger;
        target = live_items + 40;
        while (live_items < target)
            send_string();

        settle();
        $display("Covered %0d characters of numbers and noise and %0d checked results",
                 live_items, numbers_checked);
        $display("across %0d base settings, four idling mixes and a receiver hold-off.",
                 bases_used);
        if (mismatches == 0)
            $display("** unsigned_number_text_parser: PASSED **");
        else
            $display("** unsigned_number_text_parser: FAILED **");
        $finish;
    end

endmodule
